// ----- hw/rtl/gtvc_pkg.sv -----
// Shared types and constants for the verdict cache.
package gtvc_pkg;

  localparam int EntriesDef     = 16;
  localparam int PubkeyBytesDef = 32;
  localparam int CapIdBytesDef  = 16;

  localparam int CfgW = 5;
  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  localparam int WordW = 64;
  localparam logic [WordW-1:0] NeverExpires = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_QUERY  = 2'd1,
    OP_RECORD = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  // Verdict of one entry against the current request
  typedef struct packed {
    logic gen_eq;
    logic key_eq;
    logic unexpired;
  } cmp_flags_t;

endpackage

// ----- hw/rtl/gtvc_store.sv -----
// Entry store: one row per entry with key, generation and expiry, plus row valid bits.
module gtvc_store #(
  parameter int Entries = gtvc_pkg::EntriesDef,
  parameter int RowW    = 768,
  parameter int IdxW    = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [RowW-1:0] wr_row_i,
  output logic [RowW-1:0] rd_row_o
);

  logic [RowW-1:0]    mem [Entries];
  logic [RowW-1:0]    rd_data_q;
  logic               rd_vld_q;
  logic [Entries-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // An entry never written reads as all zero
  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hw/rtl/gtvc_cmp.sv -----
// Shared compare unit: judges one stored entry against the request.
module gtvc_cmp #(
  parameter int KeyW = 640
) (
  input  logic [KeyW-1:0]              ent_key_i,
  input  logic [gtvc_pkg::WordW-1:0]   ent_gen_i,
  input  logic [gtvc_pkg::WordW-1:0]   ent_exp_i,
  input  logic [KeyW-1:0]              req_key_i,
  input  logic [gtvc_pkg::WordW-1:0]   req_gen_i,
  input  logic [gtvc_pkg::WordW-1:0]   req_now_i,
  output gtvc_pkg::cmp_flags_t         flags_o
);

  assign flags_o.gen_eq    = (ent_gen_i == req_gen_i);
  assign flags_o.key_eq    = (ent_key_i == req_key_i);
  assign flags_o.unexpired = (ent_exp_i == gtvc_pkg::NeverExpires) ||
                             (req_now_i < ent_exp_i);

endmodule

// ----- hw/rtl/generation_tagged_verdict_cache.sv -----
// Top level of the verdict cache: request sequencer, key assembly and counters.
//
//   channel | signals                              | direction
//   in      | in_valid_i / in_stall_o + fields      | request word into block
//   out     | out_valid_o / out_stall_i + fields    | result word out of block
//   cfg     | cfg_we_i / cfg_wdata_i               | entries-in-use register
//
// A load goes straight to the done state. Query, record and count scan the entries in
// use through the one-read-port store and the shared compare unit, one entry per
// cycle. Generation zero or no entries in use skip the scan. The store's valid bits
// clear at reset, so no clearing pass is needed.
// The block takes one request at a time; a result held by out_stall_i holds the next
// request's completion but not its acceptance.
module generation_tagged_verdict_cache #(
  parameter int ENTRIES      = gtvc_pkg::EntriesDef,
  parameter int PUBKEY_BYTES = gtvc_pkg::PubkeyBytesDef,
  parameter int CAP_ID_BYTES = gtvc_pkg::CapIdBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  word_index_i,
  input  logic [63:0] key_word_i,
  input  logic [63:0] generation_i,
  input  logic [63:0] time_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        allowed_o,
  output logic [4:0]  live_count_o,
  output logic        status_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] miss_count_o
);

  localparam int WW       = gtvc_pkg::WordW;
  localparam int PkWords  = (PUBKEY_BYTES + 7) / 8;
  localparam int CapWords = (CAP_ID_BYTES + 7) / 8;
  localparam int KeyWords = 2 * PkWords + CapWords;
  localparam int KeyW     = KeyWords * WW;
  localparam int RowW     = KeyW + 2 * WW;
  localparam int KwIdxW   = $clog2(KeyWords);
  localparam int IdxW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW     = $clog2(ENTRIES + 1);
  localparam int CapW     = (CntW > gtvc_pkg::CfgW) ? CntW : gtvc_pkg::CfgW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  gtvc_pkg::op_e     op_q;
  logic [WW-1:0]     gen_q;
  logic [WW-1:0]     tval_q;
  logic [gtvc_pkg::CfgW-1:0] cfg_q;
  logic [WW-1:0]     key_asm_q [KeyWords];
  logic [KeyW-1:0]   key_flat;
  logic [CapW-1:0]   cap;
  logic [CapW-1:0]   rd_idx_q;
  logic [IdxW-1:0]   cmp_idx_q;
  logic              pend_q;
  logic              issue;
  logic              scan_end;
  logic              hit_q;
  logic [CapW-1:0]   cnt_q;
  logic              match_found_q;
  logic [IdxW-1:0]   match_slot_q;
  logic              alt_found_q;
  logic [IdxW-1:0]   alt_slot_q;
  logic [IdxW-1:0]   cursor_q;
  logic [IdxW-1:0]   victim;
  logic [CapW-1:0]   victim_nxt;
  logic [IdxW-1:0]   slot;
  logic              wr_en;
  logic [RowW-1:0]   rd_row;
  logic [31:0]       hit_cnt_q;
  logic [31:0]       miss_cnt_q;
  logic              res_allowed_q;
  logic [CapW-1:0]   res_live_q;
  logic              res_status_q;
  logic              out_valid_q;
  logic              out_free;
  logic              in_acc;
  gtvc_pkg::cmp_flags_t flags;

  always_comb begin
    for (int w = 0; w < KeyWords; w++) begin
      key_flat[w*WW +: WW] = key_asm_q[w];
    end
  end

  assign cap = (CapW'(cfg_q) > CapW'(ENTRIES)) ? CapW'(ENTRIES) : CapW'(cfg_q);

  assign issue    = (state_q == ST_SCAN) && (rd_idx_q < cap);
  assign scan_end = (state_q == ST_SCAN) && !issue && !pend_q;

  assign victim     = (CapW'(cursor_q) < cap) ? cursor_q : '0;
  assign victim_nxt = CapW'(victim) + CapW'(1);
  assign slot = match_found_q ? match_slot_q : (alt_found_q ? alt_slot_q : victim);
  assign wr_en = scan_end && (op_q == gtvc_pkg::OP_RECORD);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  gtvc_store #(
    .Entries (ENTRIES),
    .RowW    (RowW),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue),
    .rd_addr_i (rd_idx_q[IdxW-1:0]),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot),
    .wr_row_i  ({key_flat, gen_q, tval_q}),
    .rd_row_o  (rd_row)
  );

  gtvc_cmp #(
    .KeyW (KeyW)
  ) u_cmp (
    .ent_key_i (rd_row[RowW-1 -: KeyW]),
    .ent_gen_i (rd_row[2*WW-1 -: WW]),
    .ent_exp_i (rd_row[WW-1:0]),
    .req_key_i (key_flat),
    .req_gen_i (gen_q),
    .req_now_i (tval_q),
    .flags_o   (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= gtvc_pkg::OP_LOAD;
      gen_q         <= '0;
      tval_q        <= '0;
      cfg_q         <= gtvc_pkg::CfgReset;
      for (int w = 0; w < KeyWords; w++) begin
        key_asm_q[w] <= '0;
      end
      rd_idx_q      <= '0;
      cmp_idx_q     <= '0;
      pend_q        <= 1'b0;
      hit_q         <= 1'b0;
      cnt_q         <= '0;
      match_found_q <= 1'b0;
      match_slot_q  <= '0;
      alt_found_q   <= 1'b0;
      alt_slot_q    <= '0;
      cursor_q      <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      res_allowed_q <= 1'b0;
      res_live_q    <= '0;
      res_status_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      allowed_o     <= 1'b0;
      live_count_o  <= '0;
      status_o      <= 1'b0;
      hit_count_o   <= '0;
      miss_count_o  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q          <= gtvc_pkg::op_e'(operation_i);
            gen_q         <= generation_i;
            tval_q        <= time_value_i;
            rd_idx_q      <= '0;
            pend_q        <= 1'b0;
            hit_q         <= 1'b0;
            cnt_q         <= '0;
            match_found_q <= 1'b0;
            alt_found_q   <= 1'b0;
            res_allowed_q <= 1'b0;
            res_live_q    <= '0;
            res_status_q  <= 1'b0;
            case (gtvc_pkg::op_e'(operation_i))
              gtvc_pkg::OP_LOAD: begin
                state_q <= ST_DONE;
                if (32'(word_index_i) < KeyWords) begin
                  key_asm_q[KwIdxW'(word_index_i)] <= key_word_i;
                end
              end
              gtvc_pkg::OP_QUERY: begin
                if (generation_i == '0 || cap == '0) begin
                  miss_cnt_q <= miss_cnt_q + 32'd1;
                  state_q    <= ST_DONE;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              gtvc_pkg::OP_RECORD: begin
                if (generation_i == '0) begin
                  res_status_q <= 1'b1;
                  state_q      <= ST_DONE;
                end else if (cap != '0) begin
                  state_q <= ST_SCAN;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              default: begin
                if (generation_i != '0 && cap != '0) begin
                  state_q <= ST_SCAN;
                end else begin
                  state_q <= ST_DONE;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            rd_idx_q  <= rd_idx_q + CapW'(1);
            cmp_idx_q <= rd_idx_q[IdxW-1:0];
          end
          // Fold the verdict of the entry read last cycle
          if (pend_q) begin
            if (flags.gen_eq && flags.key_eq && flags.unexpired) begin
              hit_q <= 1'b1;
            end
            if (flags.gen_eq) begin
              cnt_q <= cnt_q + CapW'(1);
            end
            if (flags.key_eq && !match_found_q) begin
              match_found_q <= 1'b1;
              match_slot_q  <= cmp_idx_q;
            end
            if (!flags.gen_eq && !alt_found_q) begin
              alt_found_q <= 1'b1;
              alt_slot_q  <= cmp_idx_q;
            end
          end
          if (scan_end) begin
            state_q <= ST_DONE;
            case (op_q)
              gtvc_pkg::OP_QUERY: begin
                res_allowed_q <= hit_q;
                if (hit_q) begin
                  hit_cnt_q <= hit_cnt_q + 32'd1;
                end else begin
                  miss_cnt_q <= miss_cnt_q + 32'd1;
                end
              end
              gtvc_pkg::OP_RECORD: begin
                if (!match_found_q && !alt_found_q) begin
                  cursor_q <= (victim_nxt == cap) ? '0 : victim_nxt[IdxW-1:0];
                end
              end
              gtvc_pkg::OP_COUNT: begin
                res_live_q <= cnt_q;
              end
              default: begin
                res_live_q <= '0;
              end
            endcase
          end
        end
        ST_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            allowed_o    <= res_allowed_q;
            live_count_o <= res_live_q[4:0];
            status_o     <= res_status_q;
            hit_count_o  <= hit_cnt_q;
            miss_count_o <= miss_cnt_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_one_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(!$stable(hit_cnt_q) && !$stable(miss_cnt_q)))
    else $error("hit and miss counters moved together");

  a_write_on_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (op_q == gtvc_pkg::OP_RECORD && gen_q != '0))
    else $error("store written outside a record");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_SCAN))
    else $error("compare pending outside a scan");

  a_single_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && allowed_o) |-> (live_count_o == '0 && !status_o))
    else $error("query result carries count or status");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the generation-tagged verdict cache.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries = 16;
  localparam int KeyWords   = 10;
  localparam int RandItems  = 1880;
  localparam int IdleLimit  = 20000;

  typedef struct packed {
    logic        allowed;
    logic [4:0]  live_count;
    logic        status;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } verdict_t;

  typedef struct {
    gtvc_pkg::op_e op;
    logic [3:0]  widx;
    logic [63:0] word;
    logic [63:0] gen;
    logic [63:0] tval;
    logic        typed;   // expected result typed into the row
    verdict_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [3:0]  word_index_i = '0;
  logic [63:0] key_word_i = '0;
  logic [63:0] generation_i = '0;
  logic [63:0] time_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        allowed_o;
  logic [4:0]  live_count_o;
  logic        status_o;
  logic [31:0] hit_count_o;
  logic [31:0] miss_count_o;

  generation_tagged_verdict_cache dut (.*);

  // predictor state
  logic [63:0] key_reg [KeyWords];
  logic [63:0] slot_key [NumEntries][KeyWords];
  logic [63:0] slot_exp [NumEntries];
  logic [63:0] slot_gen [NumEntries];
  int unsigned cursor;
  logic [31:0] hits, misses;
  int unsigned in_use;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_long = 1'b0;
  bit drain_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit key_match(int s);
    for (int w = 0; w < KeyWords; w++) if (slot_key[s][w] != key_reg[w]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(gtvc_pkg::op_e op, logic [3:0] widx,
                                               logic [63:0] word, logic [63:0] gen,
                                               logic [63:0] tval);
    verdict_t v;
    int unsigned cap, slot;
    v = '0;
    cap = (in_use > NumEntries) ? NumEntries : in_use;
    case (op)
      gtvc_pkg::OP_LOAD: if (widx < KeyWords) key_reg[widx] = word;
      gtvc_pkg::OP_QUERY: begin
        if (gen != 0)
          for (int i = 0; i < cap; i++)
            if (slot_gen[i] == gen && key_match(i) &&
                (slot_exp[i] == gtvc_pkg::NeverExpires || tval < slot_exp[i])) begin
              v.allowed = 1'b1;
              break;
            end
        if (v.allowed) hits++; else misses++;
      end
      gtvc_pkg::OP_RECORD: begin
        if (gen == 0) v.status = 1'b1;
        else if (cap != 0) begin
          slot = cap;
          for (int i = 0; i < cap; i++) begin
            if (key_match(i)) begin slot = i; break; end
            if (slot == cap && slot_gen[i] != gen) slot = i;
          end
          if (slot == cap) begin
            slot = (cursor < cap) ? cursor : 0;
            cursor = (slot + 1) % cap;
          end
          for (int w = 0; w < KeyWords; w++) slot_key[slot][w] = key_reg[w];
          slot_exp[slot] = tval;
          slot_gen[slot] = gen;
        end
      end
      default: if (gen != 0)
        for (int i = 0; i < cap; i++) if (slot_gen[i] == gen) v.live_count++;
    endcase
    v.hit_count = hits;
    v.miss_count = misses;
    return v;
  endfunction

  // send one word and wait for its acceptance
  task automatic send_word(gtvc_pkg::op_e op, logic [3:0] widx, logic [63:0] word,
                           logic [63:0] gen, logic [63:0] tval);
    operation_i <= op;
    word_index_i <= widx;
    key_word_i <= word;
    generation_i <= gen;
    time_value_i <= tval;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(predict_verdict(op, widx, word, gen, tval));
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
          ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      operation_i <= 2'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_then_config(logic [4:0] val);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_wdata_i <= val;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    in_use = val;
  endtask

  // random key drawn from a small pool so that records and queries meet
  task automatic load_pool_key(int k);
    for (int w = 0; w < KeyWords; w++) begin
      send_word(gtvc_pkg::OP_LOAD, w[3:0], (w < 2) ? 64'(k * 7 + w) : 64'(k),
                64'($urandom), 64'($urandom));
      pause_sender();
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_gen();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return rand64();
      default: return 64'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [63:0] pick_time();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return 64'd0;
      2: return rand64();
      default: return 64'($urandom_range(0, 200));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_long = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // checker and watchdog
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: errors");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {allowed_o, live_count_o, status_o, hit_count_o, miss_count_o};
        if (pending_verdicts.size() == 0) begin
          $display("%0t unexpected word %h", $time, got);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.allowed !== want.allowed) begin
            $display("%0t allowed exp %0d got %0d", $time, want.allowed, got.allowed);
            errors++;
          end
          if (got.live_count !== want.live_count) begin
            $display("%0t live_count exp %0d got %0d", $time, want.live_count, got.live_count);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t status exp %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.hit_count !== want.hit_count) begin
            $display("%0t hit_count exp %0d got %0d", $time, want.hit_count, got.hit_count);
            errors++;
          end
          if (got.miss_count !== want.miss_count) begin
            $display("%0t miss_count exp %0d got %0d", $time, want.miss_count, got.miss_count);
            errors++;
          end
        end
      end
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(gtvc_pkg::op_e op, int widx, logic [63:0] word,
                              logic [63:0] gen, logic [63:0] tval, bit typed = 0,
                              verdict_t want = '0);
    row_t r;
    r.op = op; r.widx = widx[3:0]; r.word = word; r.gen = gen; r.tval = tval;
    r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    int k;
    logic [4:0] cfg_vals [6];
    cfg_vals = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd7};
    for (int w = 0; w < KeyWords; w++) key_reg[w] = '0;
    for (int s = 0; s < NumEntries; s++) begin
      for (int w = 0; w < KeyWords; w++) slot_key[s][w] = '0;
      slot_exp[s] = '0;
      slot_gen[s] = '0;
    end
    cursor = 0; hits = 0; misses = 0; in_use = 16;

    // directed table
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, 64'd1, 0, 1, '{0, 0, 0, 0, 1}));
    dir_rows.push_back(mk(gtvc_pkg::OP_COUNT, 0, 0, 64'd0, 0, 1, '{0, 0, 0, 0, 1}));
    dir_rows.push_back(mk(gtvc_pkg::OP_RECORD, 0, 0, 64'd0, '1, 1, '{0, 0, 1, 0, 1}));
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, 64'd0, 0, 1, '{0, 0, 0, 0, 2}));
    // zero key matches empty entry 0: refresh in place
    dir_rows.push_back(mk(gtvc_pkg::OP_RECORD, 0, 0, 64'd1, '1));
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, 64'd1, '1));
    dir_rows.push_back(mk(gtvc_pkg::OP_LOAD, 0, '1, '1, '1));
    dir_rows.push_back(mk(gtvc_pkg::OP_LOAD, 9, 64'hA5A5_5A5A_0F0F_F0F0, 0, 0));
    dir_rows.push_back(mk(gtvc_pkg::OP_LOAD, 15, '1, 0, 0));
    dir_rows.push_back(mk(gtvc_pkg::OP_LOAD, 10, 64'h1234, 0, 0));
    dir_rows.push_back(mk(gtvc_pkg::OP_RECORD, 0, 0, '1, 64'd100));
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, '1, 64'd99));
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, '1, 64'd100));
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, 64'd1, 64'd0));
    dir_rows.push_back(mk(gtvc_pkg::OP_COUNT, 0, 0, '1, 0));
    dir_rows.push_back(mk(gtvc_pkg::OP_COUNT, 0, 0, 64'd1, 0));
    dir_rows.push_back(mk(gtvc_pkg::OP_LOAD, 4, 64'h5555_5555_5555_5555, 0, 0));
    dir_rows.push_back(mk(gtvc_pkg::OP_RECORD, 0, 0, 64'd2, 64'd0));
    dir_rows.push_back(mk(gtvc_pkg::OP_QUERY, 0, 0, 64'd2, 64'd0));
    dir_rows.push_back(mk(gtvc_pkg::OP_COUNT, 0, 0, 64'd2, 0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].widx, dir_rows[i].word,
                dir_rows[i].gen, dir_rows[i].tval);
      if (dir_rows[i].typed && pending_verdicts[$] != dir_rows[i].want) begin
        $display("%0t row %0d exp %h predicted %h", $time, i, dir_rows[i].want,
                 pending_verdicts[$]);
        errors++;
      end
      pause_sender();
    end

    // random phases with different register settings
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) drain_then_config(cfg_vals[ph - 1]);
      if (ph == 2) hold_long = 1'b1;
      k = 0;
      while (k < RandItems / 7) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed: load a pool key then operate on it
          load_pool_key($urandom_range(0, 24));
          k += KeyWords;
          repeat ($urandom_range(1, 4)) begin
            send_word(gtvc_pkg::op_e'($urandom_range(1, 3)), 0, 0, pick_gen(),
                      pick_time());
            pause_sender();
            k++;
          end
        end else begin
          send_word(gtvc_pkg::op_e'($urandom_range(0, 3)), 4'($urandom), rand64(),
                    pick_gen(), pick_time());
          pause_sender();
          k++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

// ----- generation_tagged_verdict_cache.f -----
hw/rtl/gtvc_pkg.sv
hw/rtl/gtvc_store.sv
hw/rtl/gtvc_cmp.sv
hw/rtl/generation_tagged_verdict_cache.sv
tb/tb.sv
